// ----- src/e2q_pkg.sv -----
// shared constants and the arctangent table for the euler to quaternion pipeline
package e2q_pkg;

	localparam int ANGLE_FRAC_BITS_DEF = 12;
	localparam int OUT_FRAC_BITS_DEF   = 14;
	localparam int TRIG_ITERATIONS_DEF = 16;

	// trig datapath: x and y at unit 2^28, angle in q30
	localparam int  XW         = 32;
	localparam int  UNIT_SHIFT = 28;
	localparam int  QW         = 33;
	localparam int  NORM_W     = 64;
	localparam int  ROOT_W     = 32;
	localparam int  OUT_W      = 16;
	localparam int  QUO_W      = 16;

	localparam longint Q_PI      = 64'sd3373259426;
	localparam longint Q_HALF_PI = 64'sd1686629713;

	typedef logic signed [XW-1:0] trig_t;
	typedef logic signed [QW-1:0] quat_t;

	// atan(2^-i) in q30, rounded to nearest
	function automatic logic [31:0] atan_q30(input int i);
		logic [31:0] r;
		case (i)
			0:  r = 32'd843314857;
			1:  r = 32'd497837829;
			2:  r = 32'd263043837;
			3:  r = 32'd133525159;
			4:  r = 32'd67021687;
			5:  r = 32'd33543516;
			6:  r = 32'd16775851;
			7:  r = 32'd8388437;
			8:  r = 32'd4194283;
			9:  r = 32'd2097149;
			10: r = 32'd1048576;
			default: r = 32'(((64'd1 << 31) >> i) + 64'd1) >> 1;
		endcase
		return r;
	endfunction

endpackage

// ----- src/e2q_sincos.sv -----
// half-angle range reduction and pipelined rotation cordic, three lanes
module e2q_sincos #(
	parameter int ANGLE_FRAC_BITS = e2q_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int TRIG_ITERATIONS = e2q_pkg::TRIG_ITERATIONS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic signed [15:0]    angle [3],
	output logic                  out_vld,
	output e2q_pkg::trig_t        sin_v [3],
	output e2q_pkg::trig_t        cos_v [3]
);
	localparam int SH = 29 - ANGLE_FRAC_BITS;
	localparam int ZW = (((44 - ANGLE_FRAC_BITS) > 33) ? (44 - ANGLE_FRAC_BITS) : 33) + 2;
	localparam int N  = TRIG_ITERATIONS;

	e2q_pkg::trig_t       cx_s [0:N][3];
	e2q_pkg::trig_t       cy_s [0:N][3];
	logic signed [ZW-1:0] cz_s [0:N][3];
	logic                 flip_s [0:N][3];
	logic                 vld_s [0:N];
	e2q_pkg::trig_t       sin_sf [3];
	e2q_pkg::trig_t       cos_sf [3];
	logic                 vld_sf;

	logic signed [ZW-1:0] h   [3];
	logic                 flp [3];

	// half angle in q30 and fold into +-pi/2
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			h[l] = ZW'(angle[l]) <<< SH;
			flp[l] = 1'b0;
			if (h[l] > ZW'(e2q_pkg::Q_HALF_PI)) begin
				h[l] = h[l] - ZW'(e2q_pkg::Q_PI);
				flp[l] = 1'b1;
			end else if (h[l] < -ZW'(e2q_pkg::Q_HALF_PI)) begin
				h[l] = h[l] + ZW'(e2q_pkg::Q_PI);
				flp[l] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				cx_s[0][l]   <= e2q_pkg::trig_t'(64'd1 << e2q_pkg::UNIT_SHIFT);
				cy_s[0][l]   <= '0;
				cz_s[0][l]   <= h[l];
				flip_s[0][l] <= flp[l];
			end
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_iter
		localparam logic [31:0] ANG = e2q_pkg::atan_q30(k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 3; l++) begin
					flip_s[k+1][l] <= flip_s[k][l];
					if (!cz_s[k][l][ZW-1]) begin
						cx_s[k+1][l] <= cx_s[k][l] - (cy_s[k][l] >>> k);
						cy_s[k+1][l] <= cy_s[k][l] + (cx_s[k][l] >>> k);
						cz_s[k+1][l] <= cz_s[k][l] - ZW'(ANG);
					end else begin
						cx_s[k+1][l] <= cx_s[k][l] + (cy_s[k][l] >>> k);
						cy_s[k+1][l] <= cy_s[k][l] - (cx_s[k][l] >>> k);
						cz_s[k+1][l] <= cz_s[k][l] + ZW'(ANG);
					end
				end
			end
		end
	end

	// undo the fold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sf <= 1'b0;
		end else if (en) begin
			vld_sf <= vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				cos_sf[l] <= flip_s[N][l] ? -cx_s[N][l] : cx_s[N][l];
				sin_sf[l] <= flip_s[N][l] ? -cy_s[N][l] : cy_s[N][l];
			end
		end
	end

	assign out_vld = vld_sf;
	assign sin_v   = sin_sf;
	assign cos_v   = cos_sf;

endmodule

// ----- src/e2q_product.sv -----
// triple products, quaternion sums and squared norm
module e2q_product (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  e2q_pkg::trig_t             sin_v [3],
	input  e2q_pkg::trig_t             cos_v [3],
	output logic                       out_vld,
	output e2q_pkg::quat_t             quat [4],
	output logic [e2q_pkg::NORM_W-1:0] norm2
);
	localparam int SHF = e2q_pkg::UNIT_SHIFT;

	logic signed [63:0]          p_s1 [4];
	e2q_pkg::trig_t              cy_s1, sy_s1;
	logic signed [63:0]          t_s2 [8];
	e2q_pkg::quat_t              q_s3 [4];
	e2q_pkg::quat_t              q_s4 [4];
	logic [63:0]                 sq_s4 [4];
	e2q_pkg::quat_t              q_s5 [4];
	logic [e2q_pkg::NORM_W-1:0]  n2_s5;
	logic                        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	e2q_pkg::trig_t              ab [4];
	e2q_pkg::trig_t              tt [8];
	logic [31:0]                 mg [4];

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			ab[j] = e2q_pkg::trig_t'(p_s1[j] >>> SHF);
			mg[j] = 32'(q_s3[j][e2q_pkg::QW-1] ? -q_s3[j] : q_s3[j]);
		end
		for (int j = 0; j < 8; j++) begin
			tt[j] = e2q_pkg::trig_t'(t_s2[j] >>> SHF);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// roll-pitch pairs: cc, ss, sc, cs
			p_s1[0] <= 64'(cos_v[0]) * 64'(cos_v[1]);
			p_s1[1] <= 64'(sin_v[0]) * 64'(sin_v[1]);
			p_s1[2] <= 64'(sin_v[0]) * 64'(cos_v[1]);
			p_s1[3] <= 64'(cos_v[0]) * 64'(sin_v[1]);
			cy_s1   <= cos_v[2];
			sy_s1   <= sin_v[2];
			// ccc sss scc css csc scs ccs ssc
			t_s2[0] <= 64'(ab[0]) * 64'(cy_s1);
			t_s2[1] <= 64'(ab[1]) * 64'(sy_s1);
			t_s2[2] <= 64'(ab[2]) * 64'(cy_s1);
			t_s2[3] <= 64'(ab[3]) * 64'(sy_s1);
			t_s2[4] <= 64'(ab[3]) * 64'(cy_s1);
			t_s2[5] <= 64'(ab[2]) * 64'(sy_s1);
			t_s2[6] <= 64'(ab[0]) * 64'(sy_s1);
			t_s2[7] <= 64'(ab[1]) * 64'(cy_s1);
			q_s3[0] <= e2q_pkg::QW'(tt[0]) + e2q_pkg::QW'(tt[1]);
			q_s3[1] <= e2q_pkg::QW'(tt[2]) - e2q_pkg::QW'(tt[3]);
			q_s3[2] <= e2q_pkg::QW'(tt[4]) + e2q_pkg::QW'(tt[5]);
			q_s3[3] <= e2q_pkg::QW'(tt[6]) - e2q_pkg::QW'(tt[7]);
			for (int j = 0; j < 4; j++) begin
				sq_s4[j] <= 64'(mg[j]) * 64'(mg[j]);
				q_s4[j]  <= q_s3[j];
				q_s5[j]  <= q_s4[j];
			end
			n2_s5 <= sq_s4[0] + sq_s4[1] + sq_s4[2] + sq_s4[3];
		end
	end

	assign out_vld = vld_s5;
	assign quat    = q_s5;
	assign norm2   = n2_s5;

endmodule

// ----- src/e2q_isqrt.sv -----
// pipelined integer square root, one result bit per stage, with a side payload
module e2q_isqrt #(
	parameter int TAG_W = 4 * e2q_pkg::QW
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  logic [e2q_pkg::NORM_W-1:0] val,
	input  logic [TAG_W-1:0]           tag_in,
	output logic                       out_vld,
	output logic [e2q_pkg::ROOT_W-1:0] root,
	output logic [TAG_W-1:0]           tag_out
);
	localparam int RB = e2q_pkg::ROOT_W;
	localparam int RW = RB + 4;

	logic [RW-1:0]               rem_s  [0:RB];
	logic [RB-1:0]               root_s [0:RB];
	logic [e2q_pkg::NORM_W-1:0]  v_s    [0:RB];
	logic [TAG_W-1:0]            tag_s  [0:RB];
	logic                        vld_s  [0:RB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			v_s[0]    <= val;
			tag_s[0]  <= tag_in;
		end
	end

	for (genvar k = 0; k < RB; k++) begin : g_bit
		logic [RW-1:0] cur, trial;

		assign cur   = {rem_s[k][RW-3:0], v_s[k][e2q_pkg::NORM_W-1 -: 2]};
		assign trial = RW'({root_s[k], 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				v_s[k+1]   <= v_s[k] << 2;
				tag_s[k+1] <= tag_s[k];
				if (cur >= trial) begin
					rem_s[k+1]  <= cur - trial;
					root_s[k+1] <= {root_s[k][RB-2:0], 1'b1};
				end else begin
					rem_s[k+1]  <= cur;
					root_s[k+1] <= {root_s[k][RB-2:0], 1'b0};
				end
			end
		end
	end

	assign out_vld = vld_s[RB];
	assign root    = root_s[RB];
	assign tag_out = tag_s[RB];

endmodule

// ----- src/e2q_divide.sv -----
// pipelined restoring division by the norm, rounding, saturation, four lanes
module e2q_divide #(
	parameter int OUT_FRAC_BITS = e2q_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  e2q_pkg::quat_t             quat [4],
	input  logic [e2q_pkg::ROOT_W-1:0] norm,
	output logic                       out_vld,
	output logic signed [15:0]         res [4]
);
	localparam int     QB   = e2q_pkg::QUO_W;
	localparam int     NW   = e2q_pkg::QW + OUT_FRAC_BITS + 1;
	localparam int     DW   = (NW > e2q_pkg::ROOT_W + QB + 1) ? NW : e2q_pkg::ROOT_W + QB + 1;
	localparam longint ONE  = 64'sd1 <<< OUT_FRAC_BITS;
	localparam longint LIMV = (ONE > 64'sd32767) ? 64'sd32767 : ONE;
	localparam logic [QB:0] LIM = (QB+1)'(LIMV);

	logic [DW-1:0]               rem_s  [0:QB][4];
	logic [QB-1:0]               quo_s  [0:QB][4];
	logic                        sat_s  [0:QB][4];
	logic                        neg_s  [0:QB][4];
	logic [e2q_pkg::ROOT_W-1:0]  m_s    [0:QB];
	logic                        vld_s  [0:QB];
	logic signed [15:0]          res_sf [4];
	logic                        vld_sf;

	logic [DW-1:0] num  [4];
	logic [DW-1:0] mtop;
	logic [QB:0]   qv   [4];
	logic [15:0]   rv   [4];

	always_comb begin
		mtop = DW'(norm) << QB;
		for (int l = 0; l < 4; l++) begin
			num[l] = (DW'(quat[l][e2q_pkg::QW-1] ? -quat[l] : quat[l]) << OUT_FRAC_BITS)
				+ DW'(norm >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0] <= norm;
			for (int l = 0; l < 4; l++) begin
				rem_s[0][l] <= num[l];
				quo_s[0][l] <= '0;
				sat_s[0][l] <= (num[l] >= mtop);
				neg_s[0][l] <= quat[l][e2q_pkg::QW-1];
			end
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [DW-1:0] dv;

		assign dv = DW'(m_s[k]) << (QB - 1 - k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m_s[k+1] <= m_s[k];
				for (int l = 0; l < 4; l++) begin
					sat_s[k+1][l] <= sat_s[k][l];
					neg_s[k+1][l] <= neg_s[k][l];
					if (rem_s[k][l] >= dv) begin
						rem_s[k+1][l] <= rem_s[k][l] - dv;
						quo_s[k+1][l] <= {quo_s[k][l][QB-2:0], 1'b1};
					end else begin
						rem_s[k+1][l] <= rem_s[k][l];
						quo_s[k+1][l] <= {quo_s[k][l][QB-2:0], 1'b0};
					end
				end
			end
		end
	end

	// clamp, restore sign, identity on zero norm
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			qv[l] = sat_s[QB][l] ? {1'b0, {QB{1'b1}}} : {1'b0, quo_s[QB][l]};
			if (qv[l] > LIM) begin
				qv[l] = LIM;
			end
			rv[l] = 16'(qv[l]);
			if (neg_s[QB][l]) begin
				rv[l] = -rv[l];
			end
			if (m_s[QB] == '0) begin
				rv[l] = (l == 0) ? 16'(LIM) : 16'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sf <= 1'b0;
		end else if (en) begin
			vld_sf <= vld_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				res_sf[l] <= $signed(rv[l]);
			end
		end
	end

	assign out_vld = vld_sf;
	assign res     = res_sf;

endmodule

// ----- src/euler_to_quaternion.sv -----
// top level: roll, pitch and yaw angles to a normalized quaternion
// Takes one beat of three signed angles (radians, ANGLE_FRAC_BITS fraction bits)
// per clock unless a finished beat is stalled at the output, and returns one
// beat of a unit quaternion w,x,y,z (signed, OUT_FRAC_BITS fraction bits,
// clamped to plus or minus one). The pipeline accepts a new beat every cycle
// under that same condition. In order it has the fold, the TRIG_ITERATIONS
// cordic stages and the sign fixup, the triple products and norm, the square
// root (one root bit a stage), and the four-lane restoring divide (one quotient
// bit a stage) with rounding and clamping. The whole pipe advances together and
// holds only while a finished beat is stalled at the output; in that cycle
// in_stall is raised as well, so bubbles inside the pipe are not squeezed out.
module euler_to_quaternion #(
	parameter int ANGLE_FRAC_BITS = e2q_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int OUT_FRAC_BITS   = e2q_pkg::OUT_FRAC_BITS_DEF,
	parameter int TRIG_ITERATIONS = e2q_pkg::TRIG_ITERATIONS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] roll_angle,
	input  logic signed [15:0] pitch_angle,
	input  logic signed [15:0] yaw_angle,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] quat_w,
	output logic signed [15:0] quat_x,
	output logic signed [15:0] quat_y,
	output logic signed [15:0] quat_z
);
	localparam int TAG_W = 4 * e2q_pkg::QW;

	logic                        en;
	logic signed [15:0]          angle [3];
	e2q_pkg::trig_t              sin_v [3];
	e2q_pkg::trig_t              cos_v [3];
	logic                        sc_vld, pr_vld, sq_vld, dv_vld;
	e2q_pkg::quat_t              quat_p [4];
	e2q_pkg::quat_t              quat_r [4];
	logic [e2q_pkg::NORM_W-1:0]  norm2;
	logic [e2q_pkg::ROOT_W-1:0]  root;
	logic [TAG_W-1:0]            tag_in, tag_out;
	logic signed [15:0]          res [4];

	// global advance: hold everything only while a result beat is stalled
	assign en       = !(dv_vld && out_stall);
	assign in_stall = !en;

	assign angle[0] = roll_angle;
	assign angle[1] = pitch_angle;
	assign angle[2] = yaw_angle;

	e2q_sincos #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
		.TRIG_ITERATIONS(TRIG_ITERATIONS)
	) u_sincos (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (in_valid),
		.angle   (angle),
		.out_vld (sc_vld),
		.sin_v   (sin_v),
		.cos_v   (cos_v)
	);

	e2q_product u_product (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (sc_vld),
		.sin_v   (sin_v),
		.cos_v   (cos_v),
		.out_vld (pr_vld),
		.quat    (quat_p),
		.norm2   (norm2)
	);

	// quaternion rides along the square root as side payload
	assign tag_in = {quat_p[0], quat_p[1], quat_p[2], quat_p[3]};

	e2q_isqrt #(
		.TAG_W(TAG_W)
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (pr_vld),
		.val     (norm2),
		.tag_in  (tag_in),
		.out_vld (sq_vld),
		.root    (root),
		.tag_out (tag_out)
	);

	assign quat_r[0] = tag_out[4*e2q_pkg::QW-1 -: e2q_pkg::QW];
	assign quat_r[1] = tag_out[3*e2q_pkg::QW-1 -: e2q_pkg::QW];
	assign quat_r[2] = tag_out[2*e2q_pkg::QW-1 -: e2q_pkg::QW];
	assign quat_r[3] = tag_out[e2q_pkg::QW-1 -: e2q_pkg::QW];

	e2q_divide #(
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) u_divide (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (sq_vld),
		.quat    (quat_r),
		.norm    (root),
		.out_vld (dv_vld),
		.res     (res)
	);

	assign out_valid = dv_vld;
	assign quat_w    = res[0];
	assign quat_x    = res[1];
	assign quat_y    = res[2];
	assign quat_z    = res[3];

endmodule
